@@ rtl/utf8_display_width_counter_macros.svh @@
// Assertion macros shared by the checker of the UTF-8 display width counter.
`ifndef UTF8_DISPLAY_WIDTH_COUNTER_MACROS_SVH
`define UTF8_DISPLAY_WIDTH_COUNTER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define U8DW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u8dw assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define U8DW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u8dw assertion failed");

`endif

@@ rtl/u8dw_pkg.sv @@
// Shared types, constants and the wide-range function of the UTF-8 width counter.
package u8dw_pkg;

    localparam int COUNT_BITS = 16;
    localparam int BUF_DEPTH  = 4;
    localparam int CNT_BITS   = 3;
    localparam int CP_BITS    = 21;

    typedef logic [BUF_DEPTH-1:0][7:0] byte_vec_t;
    typedef logic [CNT_BITS-1:0]       pend_cnt_t;
    typedef logic [COUNT_BITS-1:0]     col_t;

    // Outcome of one decode step on the front of the pending buffer.
    typedef struct packed {
        logic       stop;
        logic [1:0] add;
        pend_cnt_t  drop;
    } step_t;

    localparam logic [CP_BITS-1:0] R0_LO = 21'h01100;
    localparam logic [CP_BITS-1:0] R0_HI = 21'h0115F;
    localparam logic [CP_BITS-1:0] R1_LO = 21'h02E80;
    localparam logic [CP_BITS-1:0] R1_HI = 21'h0A4CF;
    localparam logic [CP_BITS-1:0] R2_LO = 21'h0AC00;
    localparam logic [CP_BITS-1:0] R2_HI = 21'h0D7A3;
    localparam logic [CP_BITS-1:0] R3_LO = 21'h0F900;
    localparam logic [CP_BITS-1:0] R3_HI = 21'h0FAFF;
    localparam logic [CP_BITS-1:0] R4_LO = 21'h0FE30;
    localparam logic [CP_BITS-1:0] R4_HI = 21'h0FE6F;
    localparam logic [CP_BITS-1:0] R5_LO = 21'h0FF00;
    localparam logic [CP_BITS-1:0] R5_HI = 21'h0FF60;
    localparam logic [CP_BITS-1:0] R6_LO = 21'h0FFE0;
    localparam logic [CP_BITS-1:0] R6_HI = 21'h0FFE6;
    localparam logic [CP_BITS-1:0] R7_LO = 21'h20000;
    localparam logic [CP_BITS-1:0] R7_HI = 21'h3FFFD;

    // True when the code point occupies two display columns.
    function automatic logic wide_point(input logic [CP_BITS-1:0] cp);
        return (cp >= R0_LO && cp <= R0_HI) || (cp >= R1_LO && cp <= R1_HI) ||
               (cp >= R2_LO && cp <= R2_HI) || (cp >= R3_LO && cp <= R3_HI) ||
               (cp >= R4_LO && cp <= R4_HI) || (cp >= R5_LO && cp <= R5_HI) ||
               (cp >= R6_LO && cp <= R6_HI) || (cp >= R7_LO && cp <= R7_HI);
    endfunction

endpackage

@@ rtl/u8dw_decode.sv @@
// Decode step unit: classifies the sequence at the front of the pending buffer.
module u8dw_decode
(
    input  u8dw_pkg::byte_vec_t pend_bytes,
    input  u8dw_pkg::pend_cnt_t pend_count,
    input  logic                at_end,
    output u8dw_pkg::step_t     step
);

    logic                        lead_ok;
    u8dw_pkg::pend_cnt_t         seq_len;
    logic                        cont_ok;
    logic [u8dw_pkg::CP_BITS-1:0] cp;
    logic [2:0]                  cont;

    always_comb
    begin
        for (int k = 1; k < u8dw_pkg::BUF_DEPTH; k++)
        begin
            cont[k-1] = (pend_bytes[k][7:6] == 2'b10);
        end

        lead_ok = 1'b1;
        seq_len = 3'd1;
        cont_ok = 1'b1;
        cp      = '0;
        if (pend_bytes[0][7] == 1'b0)
        begin
            cp = {14'd0, pend_bytes[0][6:0]};
        end
        else if (pend_bytes[0][7:5] == 3'b110)
        begin
            seq_len = 3'd2;
            cont_ok = cont[0];
            cp      = {10'd0, pend_bytes[0][4:0], pend_bytes[1][5:0]};
        end
        else if (pend_bytes[0][7:4] == 4'b1110)
        begin
            seq_len = 3'd3;
            cont_ok = cont[0] & cont[1];
            cp      = {5'd0, pend_bytes[0][3:0], pend_bytes[1][5:0], pend_bytes[2][5:0]};
        end
        else if (pend_bytes[0][7:3] == 5'b11110)
        begin
            seq_len = 3'd4;
            cont_ok = &cont;
            cp      = {pend_bytes[0][2:0], pend_bytes[1][5:0], pend_bytes[2][5:0],
                       pend_bytes[3][5:0]};
        end
        else
        begin
            lead_ok = 1'b0;
        end

        step = '0;
        if (pend_count == 3'd0)
        begin
            step.stop = 1'b1;
        end
        else if (!lead_ok)
        begin
            step.add  = 2'd1;
            step.drop = 3'd1;
        end
        else if (pend_count < seq_len)
        begin
            // Incomplete sequence: wait, or at the end count it once and drop it all.
            step.stop = 1'b1;
            if (at_end)
            begin
                step.add  = 2'd1;
                step.drop = pend_count;
            end
        end
        else if (!cont_ok)
        begin
            step.add  = 2'd1;
            step.drop = 3'd1;
        end
        else
        begin
            step.add  = u8dw_pkg::wide_point(cp) ? 2'd2 : 2'd1;
            step.drop = seq_len;
        end
    end

endmodule

@@ rtl/u8dw_buffer.sv @@
// Four-byte pending buffer with append at the tail and drop from the front.
module u8dw_buffer
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                append_en,
    input  logic [7:0]          append_byte,
    input  logic                drop_en,
    input  u8dw_pkg::pend_cnt_t drop_n,
    input  logic                clear,
    output u8dw_pkg::byte_vec_t pend_bytes,
    output u8dw_pkg::pend_cnt_t pend_count
);

    u8dw_pkg::byte_vec_t bytes_reg;
    u8dw_pkg::byte_vec_t bytes_next;
    u8dw_pkg::pend_cnt_t count_reg;
    u8dw_pkg::pend_cnt_t count_next;
    u8dw_pkg::pend_cnt_t src;

    always_comb
    begin
        bytes_next = bytes_reg;
        count_next = count_reg;
        src        = '0;
        if (clear)
        begin
            count_next = '0;
        end
        else if (append_en && !count_reg[2])
        begin
            bytes_next[count_reg[1:0]] = append_byte;
            count_next = count_reg + 3'd1;
        end
        else if (drop_en)
        begin
            for (int k = 0; k < u8dw_pkg::BUF_DEPTH; k++)
            begin
                src = 3'(k) + drop_n;
                if (!src[2])
                begin
                    bytes_next[k] = bytes_reg[src[1:0]];
                end
            end
            count_next = count_reg - drop_n;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign pend_bytes = bytes_reg;
    assign pend_count = count_reg;

endmodule

@@ rtl/utf8_display_width_counter.sv @@
// Top level of the UTF-8 display width counter: sequencer, column total, result register.
// A request is accepted in ST_IDLE, then ST_DECODE applies its decode steps, one to five
// of them (at most four sequences, then the step that finds the buffer settled); in_stall
// holds off the next request until then; the single shared decode unit does every step.
// A string's total appears the cycle after its last step, which waits on a stalled total.
// Reset clears the pending byte count, the column total, the sequencer and the result valid.
module utf8_display_width_counter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        end_of_string,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] column_count
);

    // Sequencer states: waiting for a request, or stepping the decoder over the buffer.
    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_DECODE = 1'b1;

    logic                state_reg;
    logic                state_next;
    logic                end_reg;
    logic                end_next;
    u8dw_pkg::col_t      total_reg;
    u8dw_pkg::col_t      total_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [15:0]         out_count_reg;
    logic [15:0]         out_count_next;

    logic                accept;
    logic                out_busy;
    logic                apply;
    logic                finish;
    logic [u8dw_pkg::COUNT_BITS:0] sum;

    u8dw_pkg::byte_vec_t pend_bytes;
    u8dw_pkg::pend_cnt_t pend_count;
    u8dw_pkg::step_t     step;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    // The result register is free unless it holds a total that is not taken this cycle.
    assign out_busy = out_valid_reg && out_stall;

    // A step is applied every decode cycle, except the final step of a string while the
    // previous total still waits in the result register.
    assign apply  = (state_reg == ST_DECODE) && !(step.stop && end_reg && out_busy);
    assign finish = apply && step.stop && end_reg;

    u8dw_buffer u_buffer
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .append_en   (accept && byte_present),
        .append_byte (data_byte),
        .drop_en     (apply),
        .drop_n      (step.drop),
        .clear       (finish),
        .pend_bytes  (pend_bytes),
        .pend_count  (pend_count)
    );

    u8dw_decode u_decode
    (
        .pend_bytes (pend_bytes),
        .pend_count (pend_count),
        .at_end     (end_reg),
        .step       (step)
    );

    // Saturating add of the step's columns to the running total.
    assign sum = {1'b0, total_reg} + {{(u8dw_pkg::COUNT_BITS - 1){1'b0}}, step.add};

    always_comb
    begin
        state_next     = state_reg;
        end_next       = end_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_count_next = out_count_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    end_next   = end_of_string;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (apply)
                begin
                    total_next = sum[u8dw_pkg::COUNT_BITS] ? '1
                                                           : sum[u8dw_pkg::COUNT_BITS-1:0];
                    if (step.stop)
                    begin
                        state_next = ST_IDLE;
                    end
                    if (finish)
                    begin
                        // The counter width equals the output width, so the saturated
                        // total is already limited to the output maximum.
                        out_count_next = sum[u8dw_pkg::COUNT_BITS] ? '1
                                                                   : sum[15:0];
                        out_valid_next = 1'b1;
                        total_next     = '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            end_reg       <= 1'b0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            end_reg       <= end_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_count_reg <= out_count_next;
    end

    assign out_valid    = out_valid_reg;
    assign column_count = out_count_reg;

endmodule

@@ rtl/u8dw_checker.sv @@
// Port-level checker for the UTF-8 display width counter and its bind statement.
`include "utf8_display_width_counter_macros.svh"

module u8dw_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] column_count
);

    `U8DW_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(column_count))
    `U8DW_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall)
    `U8DW_ASSERT_NOW(a_result_after_work, $rose(out_valid), $past(in_stall))

endmodule

bind utf8_display_width_counter u8dw_checker u_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .column_count (column_count)
);
